// ----- rtl/ir_pulse_frame_decoder_assert.svh -----
// Assertion macros for the IR pulse frame decoder, used by irpfd_frame.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef IR_PULSE_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define IRPFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("irpfd assertion failed");
`define IRPFD_ASSERT_NEVER(lbl, cond) `IRPFD_ASSERT(lbl, !(cond))
`else
`define IRPFD_ASSERT(lbl, prop)
`define IRPFD_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/irpfd_pkg.sv -----
// Package for the IR pulse frame decoder: nominal timings, codes and shared types.
// Used by every module of the block; depends on nothing.
package irpfd_pkg;

  localparam int DURATION_BITS_DEF = 15;

  // Width used for every duration comparison; wide enough for a nominal plus margin.
  localparam int CMP_W    = 17;
  localparam int MARGIN_W = 10;

  localparam logic [CMP_W-1:0] NEC_HDR_LOW  = 17'd9000;
  localparam logic [CMP_W-1:0] NEC_HDR_HIGH = 17'd4500;
  localparam logic [CMP_W-1:0] NEC_ONE_HIGH = 17'd1690;
  localparam logic [CMP_W-1:0] P48_HDR_LOW  = 17'd3260;
  localparam logic [CMP_W-1:0] P48_ONE_HIGH = 17'd1375;

  localparam logic [5:0] NEC_BITS = 6'd32;
  localparam logic [5:0] P48_BITS = 6'd48;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd200;

  // Configuration register indexes.
  localparam logic CFG_MARGIN = 1'b0;
  localparam logic CFG_MODE   = 1'b1;

  // Protocol mode codes.
  localparam logic MODE_NEC = 1'b0;
  localparam logic MODE_P48 = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_SHORT      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_NEC  = 3'b010,
    PH_P48  = 3'b100
  } phase_t;

  // Timing verdicts on the symbol in the input register.
  typedef struct packed {
    logic hdr_good;
    logic bit_one;
  } cls_t;

endpackage

// ----- rtl/irpfd_classify.sv -----
// Duration classifier: checks a symbol's pulse widths against nominal timings.
// Depends on irpfd_pkg.
module irpfd_classify #(
  parameter int DURATION_BITS = irpfd_pkg::DURATION_BITS_DEF
) (
  input  logic [DURATION_BITS-1:0]      dur_low,
  input  logic [DURATION_BITS-1:0]      dur_high,
  input  logic [irpfd_pkg::MARGIN_W-1:0] margin,
  input  logic                          protocol_mode,
  input  irpfd_pkg::phase_t             phase,
  output irpfd_pkg::cls_t               cls
);

  // Strict window n - m < d < n + m; when m exceeds n the lower side is open.
  function automatic logic near(input logic [irpfd_pkg::CMP_W-1:0] d,
                                input logic [irpfd_pkg::CMP_W-1:0] nom,
                                input logic [irpfd_pkg::MARGIN_W-1:0] m);
    logic [irpfd_pkg::CMP_W-1:0] mw;
    mw = {{(irpfd_pkg::CMP_W-irpfd_pkg::MARGIN_W){1'b0}}, m};
    return (d < nom + mw) && ((mw > nom) || (d > nom - mw));
  endfunction

  logic [irpfd_pkg::CMP_W-1:0] low_w;
  logic [irpfd_pkg::CMP_W-1:0] high_w;
  logic [irpfd_pkg::CMP_W-1:0] one_nom;

  assign low_w   = {{(irpfd_pkg::CMP_W-DURATION_BITS){1'b0}}, dur_low};
  assign high_w  = {{(irpfd_pkg::CMP_W-DURATION_BITS){1'b0}}, dur_high};
  assign one_nom = (phase == irpfd_pkg::PH_NEC) ? irpfd_pkg::NEC_ONE_HIGH
                                                : irpfd_pkg::P48_ONE_HIGH;

  always_comb begin
    if (protocol_mode == irpfd_pkg::MODE_NEC) begin
      cls.hdr_good = near(low_w, irpfd_pkg::NEC_HDR_LOW, margin) &&
                     near(high_w, irpfd_pkg::NEC_HDR_HIGH, margin);
    end else begin
      cls.hdr_good = near(low_w, irpfd_pkg::P48_HDR_LOW, margin);
    end
    cls.bit_one = near(high_w, one_nom, margin);
  end

endmodule

// ----- rtl/irpfd_frame.sv -----
// Frame sequencer: tracks header and data bits and holds the result register.
// Depends on irpfd_pkg and ir_pulse_frame_decoder_assert.svh.
`include "ir_pulse_frame_decoder_assert.svh"
module irpfd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                sym_start,
  input  logic                sym_end,
  input  irpfd_pkg::cls_t     cls,
  input  logic                protocol_mode,
  input  logic                out_ready,
  output irpfd_pkg::phase_t   phase,
  output logic                out_valid,
  output irpfd_pkg::status_t  out_status,
  output logic [15:0]         out_address,
  output logic [15:0]         out_command
);

  irpfd_pkg::phase_t  phase_r, phase_nxt;
  logic [5:0]         bit_cnt_r, bit_cnt_nxt;
  logic [31:0]        shift_r, shift_nxt;
  logic               valid_r, valid_nxt;
  irpfd_pkg::status_t status_r, status_nxt;
  logic [31:0]        word_r, word_nxt;
  logic               emit;
  logic [5:0]         cnt_inc;
  logic [5:0]         total;
  logic [31:0]        shift_set;

  assign cnt_inc = bit_cnt_r + 6'd1;
  assign total   = (phase_r == irpfd_pkg::PH_NEC) ? irpfd_pkg::NEC_BITS
                                                  : irpfd_pkg::P48_BITS;

  always_comb begin
    shift_set = shift_r;
    if (cls.bit_one && !bit_cnt_r[5]) begin
      shift_set[bit_cnt_r[4:0]] = 1'b1;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    emit        = 1'b0;
    status_nxt  = status_r;
    word_nxt    = word_r;
    if (step) begin
      if (sym_start) begin
        bit_cnt_nxt = '0;
        shift_nxt   = '0;
        if (!cls.hdr_good) begin
          phase_nxt  = irpfd_pkg::PH_IDLE;
          emit       = 1'b1;
          status_nxt = irpfd_pkg::ST_BAD_HEADER;
          word_nxt   = '0;
        end else if (sym_end) begin
          phase_nxt  = irpfd_pkg::PH_IDLE;
          emit       = 1'b1;
          status_nxt = irpfd_pkg::ST_SHORT;
          word_nxt   = '0;
        end else begin
          phase_nxt = (protocol_mode == irpfd_pkg::MODE_NEC) ? irpfd_pkg::PH_NEC
                                                             : irpfd_pkg::PH_P48;
        end
      end else if (phase_r == irpfd_pkg::PH_NEC || phase_r == irpfd_pkg::PH_P48) begin
        if (cnt_inc >= total) begin
          phase_nxt   = irpfd_pkg::PH_IDLE;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          emit        = 1'b1;
          status_nxt  = irpfd_pkg::ST_OK;
          word_nxt    = shift_set;
        end else if (sym_end) begin
          phase_nxt   = irpfd_pkg::PH_IDLE;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          emit        = 1'b1;
          status_nxt  = irpfd_pkg::ST_SHORT;
          word_nxt    = '0;
        end else begin
          bit_cnt_nxt = cnt_inc;
          shift_nxt   = shift_set;
        end
      end else begin
        phase_nxt = irpfd_pkg::PH_IDLE;
      end
    end
    valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= irpfd_pkg::PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      valid_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    word_r   <= word_nxt;
  end

  assign phase       = phase_r;
  assign out_valid   = valid_r;
  assign out_status  = status_r;
  assign out_address = word_r[15:0];
  assign out_command = word_r[31:16];

  `IRPFD_ASSERT(a_cnt_range, bit_cnt_r < irpfd_pkg::P48_BITS)
  `IRPFD_ASSERT(a_nec_cnt, (phase_r == irpfd_pkg::PH_NEC) |-> (bit_cnt_r < irpfd_pkg::NEC_BITS))
  `IRPFD_ASSERT(a_idle_clear, (phase_r == irpfd_pkg::PH_IDLE) |-> (bit_cnt_r == 6'd0 && shift_r == 32'd0))
  `IRPFD_ASSERT_NEVER(a_err_payload, valid_r && status_r != irpfd_pkg::ST_OK && word_r != 32'd0)
  `IRPFD_ASSERT(a_rise_from_step, $rose(valid_r) |-> $past(step))

endmodule

// ----- rtl/ir_pulse_frame_decoder.sv -----
// IR pulse frame decoder top level: stream ports, configuration registers, input register.
// Depends on irpfd_pkg, irpfd_classify and irpfd_frame.
//
// The block decodes infrared remote frames from captured symbols, one symbol per
// input item: a low duration and a high duration in ticks, with tuser marking the
// header symbol of a new frame and tlast the last symbol the receiver captured.
// In NEC mode (protocol_mode 0) the header must lie within the margin of 9000 low and
// 4500 high, and 32 data bits follow; in 48-bit mode (protocol_mode 1) only the
// header low time is checked against 3260, and 48 data bits follow. All windows are
// strict on both sides. A data bit is a one when its high time is near 1690 (NEC) or
// 1375 (48-bit); bits arrive first bit first, so the first sixteen form the address
// and the next sixteen the command, while bits 32 to 47 of a 48-bit frame are counted
// and dropped. Each frame yields at most one result item: status ok with the decoded
// words, bad header, or short frame (tlast before the final bit); address and command
// are zero unless the status is ok. Symbols outside a frame give nothing, and a new
// header abandons an unfinished frame silently. Each item is captured in the input
// register, then classified and sequenced once the output register can take a result,
// and any result lands in the output register, so a fresh item is accepted on every
// clock while the result side keeps up. Configuration may only be written while no
// frame is in progress and no result is pending; protocol_mode is sampled at the header.
module ir_pulse_frame_decoder #(
  parameter int DURATION_BITS = irpfd_pkg::DURATION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Symbol input.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, lowest bit up: duration_low, duration_high, zero fill to whole bytes.
  input  logic [((2*DURATION_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: frame_start.
  input  logic                             in_tuser,
  // tlast: frame_end.
  input  logic                             in_tlast,
  // Result output.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, lowest bit up: address, command.
  output logic [31:0]                      out_tdata,
  // tuser: status.
  output logic [1:0]                       out_tuser,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [irpfd_pkg::MARGIN_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [irpfd_pkg::MARGIN_W-1:0] margin_r, margin_nxt;
  logic                           mode_r, mode_nxt;

  // Input register holding the symbol under decode.
  logic                     s1_valid_r, s1_valid_nxt;
  logic [DURATION_BITS-1:0] s1_low_r, s1_high_r;
  logic                     s1_start_r, s1_end_r;

  logic                 in_accept;
  logic                 out_free;
  logic                 step;
  irpfd_pkg::cls_t      cls;
  irpfd_pkg::phase_t    phase;
  irpfd_pkg::status_t   status;
  logic [15:0]          address;
  logic [15:0]          command;

  // Configuration is always taken; the user must write only while the block is quiet, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_comb begin
    margin_nxt = margin_r;
    mode_nxt   = mode_r;
    if (cfg_valid) begin
      case (cfg_index)
        irpfd_pkg::CFG_MARGIN: margin_nxt = cfg_data;
        irpfd_pkg::CFG_MODE:   mode_nxt   = cfg_data[0];
        default:               margin_nxt = margin_r;
      endcase
    end
  end

  // The held symbol is decoded once the output register can take a result, which
  // leaves a waiting result and a newly accepted item side by side.
  assign out_free     = !out_tvalid || out_tready;
  assign step         = s1_valid_r && out_free;
  assign in_tready    = !s1_valid_r || out_free;
  assign in_accept    = in_tvalid && in_tready;
  assign s1_valid_nxt = in_accept ? 1'b1 : (step ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r   <= irpfd_pkg::MARGIN_RESET;
      mode_r     <= irpfd_pkg::MODE_NEC;
      s1_valid_r <= 1'b0;
    end else begin
      margin_r   <= margin_nxt;
      mode_r     <= mode_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_low_r   <= in_tdata[DURATION_BITS-1:0];
      s1_high_r  <= in_tdata[2*DURATION_BITS-1:DURATION_BITS];
      s1_start_r <= in_tuser;
      s1_end_r   <= in_tlast;
    end
  end

  irpfd_classify #(
    .DURATION_BITS(DURATION_BITS)
  ) u_classify (
    .dur_low      (s1_low_r),
    .dur_high     (s1_high_r),
    .margin       (margin_r),
    .protocol_mode(mode_r),
    .phase        (phase),
    .cls          (cls)
  );

  irpfd_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .sym_start    (s1_start_r),
    .sym_end      (s1_end_r),
    .cls          (cls),
    .protocol_mode(mode_r),
    .out_ready    (out_tready),
    .phase        (phase),
    .out_valid    (out_tvalid),
    .out_status   (status),
    .out_address  (address),
    .out_command  (command)
  );

  assign out_tdata = {command, address};
  assign out_tuser = status;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the IR pulse frame decoder: directed and random symbol streams.
// Depends on irpfd_pkg and ir_pulse_frame_decoder; expected frames come from a built-in model.
module tb_top;

  localparam int DUR_W          = irpfd_pkg::DURATION_BITS_DEF;
  localparam int IN_W           = ((2*DUR_W+7)/8)*8;
  localparam int DUR_MAX        = (1 << DUR_W) - 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;

  // One decoded frame as the block should report it.
  typedef struct {
    irpfd_pkg::status_t status;
    logic [15:0]        address;
    logic [15:0]        command;
  } frame_result_t;

  // Shapes of symbol sequence that the random part produces.
  typedef enum int {
    FK_GOOD,
    FK_SHORT,
    FK_BAD_HDR,
    FK_HDR_END,
    FK_RESTART,
    FK_NOISE
  } frame_kind_t;

  // Frame decoder model and result checker. decode_symbol is called for every accepted
  // item and queues the frame result that item completes; check_result compares each
  // accepted result item with the oldest queued frame.
  class ir_frame_scoreboard;
    logic [irpfd_pkg::MARGIN_W-1:0] margin;
    logic                           mode;
    irpfd_pkg::phase_t              phase;
    logic [5:0]                     bit_count;
    logic [31:0]                    data_shift;
    frame_result_t                  expected_frames[$];
    int                             failures;
    int                             symbols_used;

    function new();
      margin       = irpfd_pkg::MARGIN_RESET;
      mode         = irpfd_pkg::MODE_NEC;
      phase        = irpfd_pkg::PH_IDLE;
      bit_count    = '0;
      data_shift   = '0;
      failures     = 0;
      symbols_used = 0;
    endfunction

    // Strict window on both sides; a margin wider than the nominal has no lower bound.
    static function bit is_near(int d, int nominal, int m);
      if (m > nominal) return d < nominal + m;
      return (d < nominal + m) && (d > nominal - m);
    endfunction

    function void write_reg(logic idx, logic [irpfd_pkg::MARGIN_W-1:0] value);
      if (idx == irpfd_pkg::CFG_MARGIN) margin = value;
      else mode = value[0];
    endfunction

    function void push_result(irpfd_pkg::status_t st, logic [31:0] word);
      frame_result_t r;
      r.status  = st;
      r.address = word[15:0];
      r.command = word[31:16];
      expected_frames.push_back(r);
    endfunction

    function void decode_symbol(logic [DUR_W-1:0] dlow, logic [DUR_W-1:0] dhigh,
                                logic start, logic last);
      bit         good;
      bit         one;
      logic [5:0] total;
      if (start) begin
        symbols_used++;
        bit_count  = '0;
        data_shift = '0;
        if (mode == irpfd_pkg::MODE_NEC)
          good = is_near(int'(dlow), int'(irpfd_pkg::NEC_HDR_LOW), int'(margin)) &&
                 is_near(int'(dhigh), int'(irpfd_pkg::NEC_HDR_HIGH), int'(margin));
        else
          good = is_near(int'(dlow), int'(irpfd_pkg::P48_HDR_LOW), int'(margin));
        if (!good) begin
          phase = irpfd_pkg::PH_IDLE;
          push_result(irpfd_pkg::ST_BAD_HEADER, '0);
        end else if (last) begin
          phase = irpfd_pkg::PH_IDLE;
          push_result(irpfd_pkg::ST_SHORT, '0);
        end else begin
          phase = (mode == irpfd_pkg::MODE_NEC) ? irpfd_pkg::PH_NEC : irpfd_pkg::PH_P48;
        end
        return;
      end
      // Outside a frame a data symbol is simply dropped.
      if (phase != irpfd_pkg::PH_NEC && phase != irpfd_pkg::PH_P48) begin
        phase = irpfd_pkg::PH_IDLE;
        return;
      end
      symbols_used++;
      if (phase == irpfd_pkg::PH_NEC) begin
        total = irpfd_pkg::NEC_BITS;
        one   = is_near(int'(dhigh), int'(irpfd_pkg::NEC_ONE_HIGH), int'(margin));
      end else begin
        total = irpfd_pkg::P48_BITS;
        one   = is_near(int'(dhigh), int'(irpfd_pkg::P48_ONE_HIGH), int'(margin));
      end
      if (one && bit_count < 6'd32) data_shift[bit_count[4:0]] = 1'b1;
      bit_count = bit_count + 6'd1;
      if (bit_count >= total) begin
        push_result(irpfd_pkg::ST_OK, data_shift);
        phase      = irpfd_pkg::PH_IDLE;
        bit_count  = '0;
        data_shift = '0;
      end else if (last) begin
        push_result(irpfd_pkg::ST_SHORT, '0);
        phase      = irpfd_pkg::PH_IDLE;
        bit_count  = '0;
        data_shift = '0;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] address,
                               logic [15:0] command);
      frame_result_t exp_r;
      if (expected_frames.size() == 0) begin
        $error("result item with no frame expected: status %0d, address %h, command %h",
               status, address, command);
        failures++;
        return;
      end
      exp_r = expected_frames.pop_front();
      if (status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, status);
        failures++;
      end
      if (address !== exp_r.address) begin
        $error("address: expected %h, actual %h", exp_r.address, address);
        failures++;
      end
      if (command !== exp_r.command) begin
        $error("command: expected %h, actual %h", exp_r.command, command);
        failures++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function bit in_frame();
      return phase != irpfd_pkg::PH_IDLE;
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  // tdata, lowest bit up: duration_low, duration_high, zero fill.
  logic [IN_W-1:0]                in_tdata;
  // tuser: frame_start.
  logic                           in_tuser;
  // tlast: frame_end.
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  // tdata, lowest bit up: address, command.
  logic [31:0]                    out_tdata;
  // tuser: status.
  logic [1:0]                     out_tuser;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_index;
  logic [irpfd_pkg::MARGIN_W-1:0] cfg_data;

  ir_frame_scoreboard sb;

  // Flags for the stimulus and the result sink.
  bit quiet;        // last part of the run: no idling on either side
  bit calm;         // current frame is sent without gaps
  bit hold_req;     // ask the sink for one long hold-off
  bit hold_served;
  int cur_margin;   // settings the generator aims its durations at
  bit cur_mode;

  ir_pulse_frame_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // All handshakes are observed at the rising edge, where every input still holds the
  // value driven at the previous edge, so the model sees exactly what the block sees.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        sb.decode_symbol(in_tdata[DUR_W-1:0], in_tdata[2*DUR_W-1:DUR_W], in_tuser, in_tlast);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[15:0], out_tdata[31:16]);
    end
  end

  // The run is abandoned if no channel moves an item for a long stretch.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  // Result sink: random bursts of stalls and acceptance, one long hold-off on request
  // so that the block fills and pushes back on its input, and no stalls at the end.
  initial begin : result_sink
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offers one symbol and returns at the edge where it is accepted. The next call
  // either drives the following item at that same edge or opens a gap first.
  task automatic send_symbol(int dl, int dh, bit start, bit last);
    logic [DUR_W-1:0] dl_v;
    logic [DUR_W-1:0] dh_v;
    dl_v = dl[DUR_W-1:0];
    dh_v = dh[DUR_W-1:0];
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-2*DUR_W){1'b0}}, dh_v, dl_v};
    in_tuser  <= start;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // A duration aimed at the window around a nominal; the edges of the window, just
  // inside and just outside, are picked now and then.
  function automatic int pick_near(int nominal);
    int d;
    case ($urandom_range(0, 15))
      0:       d = nominal - cur_margin;
      1:       d = nominal + cur_margin;
      2:       d = nominal - cur_margin + 1;
      3:       d = nominal + cur_margin - 1;
      default: d = nominal - cur_margin + int'($urandom_range(0, 2*cur_margin));
    endcase
    if (d < 0) d = 0;
    if (d > DUR_MAX) d = DUR_MAX;
    return d;
  endfunction

  // A duration outside the window, often right on its boundary.
  function automatic int pick_far(int nominal);
    int d;
    if ($urandom_range(0, 3) == 0) begin
      d = $urandom_range(0, 1) ? nominal + cur_margin : nominal - cur_margin;
    end else begin
      do d = int'($urandom_range(0, DUR_MAX));
      while (ir_frame_scoreboard::is_near(d, nominal, cur_margin));
    end
    return d;
  endfunction

  task automatic send_header(bit good, bit last);
    int dl;
    int dh;
    if (cur_mode == irpfd_pkg::MODE_NEC) begin
      if (good) begin
        dl = pick_near(int'(irpfd_pkg::NEC_HDR_LOW));
        dh = pick_near(int'(irpfd_pkg::NEC_HDR_HIGH));
      end else if ($urandom_range(0, 1)) begin
        dl = pick_far(int'(irpfd_pkg::NEC_HDR_LOW));
        dh = int'($urandom_range(0, DUR_MAX));
      end else begin
        dl = pick_near(int'(irpfd_pkg::NEC_HDR_LOW));
        dh = pick_far(int'(irpfd_pkg::NEC_HDR_HIGH));
      end
    end else begin
      // Only the low time of a 48-bit header matters.
      dl = good ? pick_near(int'(irpfd_pkg::P48_HDR_LOW))
                : pick_far(int'(irpfd_pkg::P48_HDR_LOW));
      dh = int'($urandom_range(0, DUR_MAX));
    end
    send_symbol(dl, dh, 1'b1, last);
  endtask

  // Data symbols; a few frames carry all ones or all zeros to reach the word extremes.
  task automatic send_bits(int count, bit last_on_final);
    int one_nom;
    int pattern;
    int i;
    bit b;
    one_nom = (cur_mode == irpfd_pkg::MODE_NEC) ? int'(irpfd_pkg::NEC_ONE_HIGH)
                                                : int'(irpfd_pkg::P48_ONE_HIGH);
    pattern = int'($urandom_range(0, 7));
    for (i = 0; i < count; i++) begin
      if (pattern == 0) b = 1'b0;
      else if (pattern == 1) b = 1'b1;
      else b = 1'($urandom_range(0, 1));
      send_symbol(int'($urandom_range(0, DUR_MAX)),
                  b ? pick_near(one_nom) : pick_far(one_nom),
                  1'b0, last_on_final && (i == count - 1));
    end
  endtask

  function automatic frame_kind_t pick_kind();
    int w;
    w = int'($urandom_range(0, 99));
    if (w < 45) return FK_GOOD;
    if (w < 60) return FK_SHORT;
    if (w < 70) return FK_BAD_HDR;
    if (w < 78) return FK_HDR_END;
    if (w < 88) return FK_RESTART;
    return FK_NOISE;
  endfunction

  task automatic send_frame(frame_kind_t kind);
    int total;
    total = (cur_mode == irpfd_pkg::MODE_NEC) ? int'(irpfd_pkg::NEC_BITS)
                                              : int'(irpfd_pkg::P48_BITS);
    calm  = ($urandom_range(0, 3) == 0);
    case (kind)
      FK_GOOD: begin
        // Complete frame, with or without tlast on its final bit, and sometimes a few
        // stray symbols after it that the block must ignore.
        send_header(1'b1, 1'b0);
        send_bits(total, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2))
          send_symbol(int'($urandom_range(0, DUR_MAX)), int'($urandom_range(0, DUR_MAX)),
                      1'b0, 1'($urandom_range(0, 1)));
      end
      FK_SHORT: begin
        send_header(1'b1, 1'b0);
        send_bits(int'($urandom_range(1, total - 1)), 1'b1);
      end
      FK_BAD_HDR: begin
        send_header(1'b0, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3))
          send_symbol(int'($urandom_range(0, DUR_MAX)), int'($urandom_range(0, DUR_MAX)),
                      1'b0, 1'b0);
      end
      FK_HDR_END: send_header(1'b1, 1'b1);
      FK_RESTART: begin
        // Left open on purpose; the next header abandons it unless later symbols end it first.
        send_header(1'b1, 1'b0);
        send_bits(int'($urandom_range(0, total - 1)), 1'b0);
      end
      default: begin
        repeat ($urandom_range(1, 4))
          send_symbol(int'($urandom_range(0, DUR_MAX)), int'($urandom_range(0, DUR_MAX)),
                      $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // Brings the block to rest: closes any open frame with a header that can never pass,
  // waits for every expected result and then for the pipeline to drain.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    if (sb.in_frame()) begin
      send_symbol(0, 0, 1'b1, 1'b1);
      in_tvalid <= 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; valid stays high between the two items.
  task automatic apply_settings(int m, bit mode);
    cfg_valid <= 1'b1;
    cfg_index <= irpfd_pkg::CFG_MARGIN;
    cfg_data  <= m[irpfd_pkg::MARGIN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= irpfd_pkg::CFG_MODE;
    cfg_data  <= {{(irpfd_pkg::MARGIN_W-1){1'b0}}, mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_margin = m;
    cur_mode   = mode;
  endtask

  initial begin : stimulus
    int phase_margin[NUM_PHASES];
    bit phase_mode[NUM_PHASES];
    int phase_budget[NUM_PHASES];
    int target;
    int p;
    int nec_lo;
    int nec_hi;
    int nec_one;

    // Settings per phase: margins 1023 and 1 in both modes, margin zero (48-bit mode) where
    // nothing is ever in its window, one random setting, and the reset values at the end.
    // Small margins make most headers fail, so those phases are kept short.
    phase_margin = '{1023, 200, 1, 0, 1023, 1, 0, 200};
    phase_mode   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    phase_budget = '{280, 280, 120, 12, 280, 120, 280, 250};
    phase_margin[6] = int'($urandom_range(2, 1022));
    phase_mode[6]   = 1'($urandom_range(0, 1));
    nec_lo  = int'(irpfd_pkg::NEC_HDR_LOW);
    nec_hi  = int'(irpfd_pkg::NEC_HDR_HIGH);
    nec_one = int'(irpfd_pkg::NEC_ONE_HIGH);

    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= irpfd_pkg::CFG_MARGIN;
    cfg_data  <= '0;
    quiet       = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    hold_served = 1'b0;
    cur_margin  = int'(irpfd_pkg::MARGIN_RESET);
    cur_mode    = irpfd_pkg::MODE_NEC;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset settings (margin 200, NEC).
    // Data symbols while idle, at both extremes of the durations, give nothing.
    send_symbol(0, 0, 1'b0, 1'b0);
    send_symbol(DUR_MAX, DUR_MAX, 1'b0, 1'b1);
    // Headers: far off, good but also flagged as the last symbol, bad and last.
    send_symbol(DUR_MAX, DUR_MAX, 1'b1, 1'b0);
    send_symbol(nec_lo, nec_hi, 1'b1, 1'b1);
    send_symbol(0, 0, 1'b1, 1'b1);
    // Window edges: one tick inside passes, the boundary itself does not.
    send_symbol(nec_lo + 199, nec_hi - 199, 1'b1, 1'b1);
    send_symbol(nec_lo + 200, nec_hi, 1'b1, 1'b1);
    // Ones at the nominal and just inside the edge, a zero on it; a new header drops them.
    send_symbol(nec_lo - 199, nec_hi + 199, 1'b1, 1'b0);
    send_symbol(560, nec_one, 1'b0, 1'b0);
    send_symbol(560, nec_one + 199, 1'b0, 1'b0);
    send_symbol(560, nec_one + 200, 1'b0, 1'b0);
    send_symbol(nec_lo, nec_hi, 1'b1, 1'b0);
    // The replacement frame ends too early, and the symbol after it is ignored.
    send_symbol(DUR_MAX, 0, 1'b0, 1'b0);
    send_symbol(0, DUR_MAX, 1'b0, 1'b1);
    send_symbol(100, 200, 1'b0, 1'b1);
    settle_block();

    // Back-pressure: the sink holds off for a long stretch while bad headers, each
    // giving a result, are offered without gaps until the block stalls its input.
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_header(1'b0, 1'b0);
    settle_block();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      apply_settings(phase_margin[p], phase_mode[p]);
      target = sb.symbols_used + phase_budget[p];
      while (sb.symbols_used < target) send_frame(pick_kind());
      settle_block();
    end

    if (sb.failures == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
